FILE: src/playfair_digraph_cipher_macros.svh
// assertion macros shared by the playfair digraph cipher rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled while reset is held
`define PFC_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("pfc assertion failed");

// next-cycle implication, disabled while reset is held
`define PFC_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("pfc assertion failed");

`else

`define PFC_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define PFC_ASSERT_NXT(label, clk, rst_n, cond, prop)

`endif

`endif

FILE: src/pfc_pkg.sv
// shared constants, types and helpers of the playfair digraph cipher
// no dependencies; imported by every module and interface of the block
package pfc_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int CODE_W      = 5;
    localparam int ROW_W       = SQUARE_SIDE * CODE_W;
    localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
    localparam int POS_W       = $clog2(SQUARE_SIDE);
    localparam int CFG_IDX_W   = 3;

    typedef logic [CODE_W-1:0]                  t_code;
    typedef logic [POS_W-1:0]                   t_pos;
    typedef logic [ROW_W-1:0]                   t_row;
    typedef logic [SQUARE_SIDE-1:0][ROW_W-1:0]  t_square;
    typedef logic [CELLS-1:0]                   t_match;
    typedef logic [CFG_IDX_W-1:0]               t_cfg_idx;

    localparam t_code CODE_I = t_code'(8);
    localparam t_code CODE_J = t_code'(9);
    localparam t_code CODE_Z = t_code'(25);

    // configuration register indexes
    localparam t_cfg_idx REG_ROW_0 = t_cfg_idx'(0);
    localparam t_cfg_idx REG_ROW_1 = t_cfg_idx'(1);
    localparam t_cfg_idx REG_ROW_2 = t_cfg_idx'(2);
    localparam t_cfg_idx REG_ROW_3 = t_cfg_idx'(3);
    localparam t_cfg_idx REG_ROW_4 = t_cfg_idx'(4);
    localparam t_cfg_idx REG_MODE  = t_cfg_idx'(5);

    localparam t_pos POS_LAST = t_pos'(SQUARE_SIDE - 1);

    typedef struct packed {
        logic found;
        t_pos r1;
        t_pos c1;
        t_pos r2;
        t_pos c2;
    } t_loc_s;

    typedef struct packed {
        t_code first;
        t_code second;
        logic  pair_valid;
    } t_res_s;

    function automatic t_code cell_at(t_square sq, t_pos row, t_pos col);
        t_code c;
        c = '0;
        for (int r = 0; r < SQUARE_SIDE; r++) begin
            for (int k = 0; k < SQUARE_SIDE; k++) begin
                if (row == t_pos'(r) && col == t_pos'(k)) begin
                    c = sq[r][k*CODE_W +: CODE_W];
                end
            end
        end
        return c;
    endfunction

    // one step around the square, backward when decrypting
    function automatic t_pos shift_pos(t_pos pos, logic dec);
        t_pos p;
        if (dec) begin
            p = (pos == '0) ? POS_LAST : t_pos'(pos - t_pos'(1));
        end else begin
            p = (pos == POS_LAST) ? '0 : t_pos'(pos + t_pos'(1));
        end
        return p;
    endfunction

endpackage

FILE: src/pfc_ifs.sv
// valid/ready channel interfaces of the playfair digraph cipher
// depends on pfc_pkg
interface pfc_in_if import pfc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_code first_letter;
    t_code second_letter;

    modport source (output valid, output first_letter, output second_letter, input ready);
    modport sink   (input valid, input first_letter, input second_letter, output ready);
endinterface

interface pfc_out_if import pfc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_code out_first;
    t_code out_second;
    logic  pair_valid;

    modport source (output valid, output out_first, output out_second, output pair_valid,
                    input ready);
    modport sink   (input valid, input out_first, input out_second, input pair_valid,
                    output ready);
endinterface

interface pfc_cfg_if import pfc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_row     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/pfc_match.sv
// first pipeline stage: compares both letters against all 25 square cells
// depends on pfc_pkg
module pfc_match import pfc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_code   i_first,
    input  t_code   i_second,
    input  t_square i_square,
    output logic    o_valid,
    output t_match  o_m1,
    output t_match  o_m2
);

    logic   r_valid;
    t_match r_m1, r_m2;
    t_match n_m1, n_m2;
    t_code  k1, k2;
    logic   ok1, ok2;

    always_comb begin
        // j is searched as i, codes past z never match
        k1  = (i_first == CODE_J) ? CODE_I : i_first;
        k2  = (i_second == CODE_J) ? CODE_I : i_second;
        ok1 = (i_first <= CODE_Z);
        ok2 = (i_second <= CODE_Z);
        for (int r = 0; r < SQUARE_SIDE; r++) begin
            for (int c = 0; c < SQUARE_SIDE; c++) begin
                n_m1[r*SQUARE_SIDE + c] = ok1 && (i_square[r][c*CODE_W +: CODE_W] == k1);
                n_m2[r*SQUARE_SIDE + c] = ok2 && (i_square[r][c*CODE_W +: CODE_W] == k2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m1 <= n_m1;
            r_m2 <= n_m2;
        end
    end

    assign o_valid = r_valid;
    assign o_m1    = r_m1;
    assign o_m2    = r_m2;

endmodule

FILE: src/pfc_locate.sv
// second pipeline stage: priority-encodes the match vectors into row and column
// depends on pfc_pkg
module pfc_locate import pfc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_valid,
    input  t_match i_m1,
    input  t_match i_m2,
    output logic   o_valid,
    output t_loc_s o_loc
);

    logic   r_valid;
    t_loc_s r_loc;
    t_loc_s n_loc;

    always_comb begin
        n_loc       = '0;
        n_loc.found = (|i_m1) && (|i_m2);
        // walk from the last cell down so the first cell in row-major order wins
        for (int r = SQUARE_SIDE - 1; r >= 0; r--) begin
            for (int c = SQUARE_SIDE - 1; c >= 0; c--) begin
                if (i_m1[r*SQUARE_SIDE + c]) begin
                    n_loc.r1 = t_pos'(r);
                    n_loc.c1 = t_pos'(c);
                end
                if (i_m2[r*SQUARE_SIDE + c]) begin
                    n_loc.r2 = t_pos'(r);
                    n_loc.c2 = t_pos'(c);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_loc <= n_loc;
        end
    end

    assign o_valid = r_valid;
    assign o_loc   = r_loc;

endmodule

FILE: src/pfc_select.sv
// third and fourth pipeline stages: applies the playfair rule to get target
// cells, then reads them out of the square; depends on pfc_pkg
module pfc_select import pfc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_valid,
    input  t_loc_s  i_loc,
    input  t_square i_square,
    input  logic    i_decrypt,
    output logic    o_valid,
    output t_res_s  o_res
);

    logic   r_tgt_valid;
    t_loc_s r_tgt;
    t_loc_s n_tgt;
    logic   r_res_valid;
    t_res_s r_res;
    t_res_s n_res;

    always_comb begin
        n_tgt = i_loc;
        if (i_loc.c1 == i_loc.c2) begin
            // same column, also covers a doubled letter
            n_tgt.r1 = shift_pos(i_loc.r1, i_decrypt);
            n_tgt.r2 = shift_pos(i_loc.r2, i_decrypt);
        end else if (i_loc.r1 == i_loc.r2) begin
            n_tgt.c1 = shift_pos(i_loc.c1, i_decrypt);
            n_tgt.c2 = shift_pos(i_loc.c2, i_decrypt);
        end else begin
            // rectangle: swap columns
            n_tgt.c1 = i_loc.c2;
            n_tgt.c2 = i_loc.c1;
        end
    end

    always_comb begin
        n_res = '0;
        if (r_tgt.found) begin
            n_res.first      = cell_at(i_square, r_tgt.r1, r_tgt.c1);
            n_res.second     = cell_at(i_square, r_tgt.r2, r_tgt.c2);
            n_res.pair_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_valid <= 1'b0;
            r_res_valid <= 1'b0;
        end else if (i_en) begin
            r_tgt_valid <= i_valid;
            r_res_valid <= r_tgt_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tgt <= n_tgt;
            r_res <= n_res;
        end
    end

    assign o_valid = r_res_valid;
    assign o_res   = r_res;

endmodule

FILE: src/playfair_digraph_cipher.sv
// Playfair digraph cipher: one letter pair in, one transformed pair out. The
// datapath is four register stages (cell compare, position encode, rule, cell
// read); a new pair is taken every cycle while the pipeline is not frozen. The
// last stage is the output register; while it holds an untaken result the whole
// pipeline freezes and input ready drops. Key square rows and the decrypt bit are
// written through the config channel, by the user only while no pairs are in
// flight (the block does not enforce this); config writes are taken every cycle.
// depends on pfc_pkg, pfc_ifs, pfc_match, pfc_locate, pfc_select
`include "playfair_digraph_cipher_macros.svh"

module playfair_digraph_cipher import pfc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    pfc_in_if.sink    i_in,
    pfc_cfg_if.sink   i_cfg,
    pfc_out_if.source o_out
);

    t_square r_square;
    logic    r_decrypt;
    logic    en;
    logic    s1_valid, s2_valid, s4_valid;
    t_match  s1_m1, s1_m2;
    t_loc_s  s2_loc;
    t_res_s  s4_res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square  <= '0;
            r_decrypt <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_ROW_0: r_square[0] <= i_cfg.data;
                REG_ROW_1: r_square[1] <= i_cfg.data;
                REG_ROW_2: r_square[2] <= i_cfg.data;
                REG_ROW_3: r_square[3] <= i_cfg.data;
                REG_ROW_4: r_square[4] <= i_cfg.data;
                REG_MODE:  r_decrypt   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless a finished result is waiting
    assign en         = !s4_valid || o_out.ready;
    assign i_in.ready = en;

    pfc_match u_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in.valid),
        .i_first  (i_in.first_letter),
        .i_second (i_in.second_letter),
        .i_square (r_square),
        .o_valid  (s1_valid),
        .o_m1     (s1_m1),
        .o_m2     (s1_m2)
    );

    pfc_locate u_locate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (s1_valid),
        .i_m1    (s1_m1),
        .i_m2    (s1_m2),
        .o_valid (s2_valid),
        .o_loc   (s2_loc)
    );

    pfc_select u_select (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (s2_valid),
        .i_loc     (s2_loc),
        .i_square  (r_square),
        .i_decrypt (r_decrypt),
        .o_valid   (s4_valid),
        .o_res     (s4_res)
    );

    assign o_out.valid      = s4_valid;
    assign o_out.out_first  = s4_res.first;
    assign o_out.out_second = s4_res.second;
    assign o_out.pair_valid = s4_res.pair_valid;

    `PFC_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_out.valid && !o_out.pair_valid, o_out.out_first == '0 && o_out.out_second == '0)
    `PFC_ASSERT_IMP(a_stall_blocks_in, i_clk, i_rst_n, o_out.valid && !o_out.ready, !i_in.ready)
    `PFC_ASSERT_NXT(a_in_lands, i_clk, i_rst_n, i_in.valid && i_in.ready, s1_valid)

endmodule
